// ===== hdl/rclc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package rclc_pkg;

    localparam int CAPACITY        = 256;
    localparam int TURNS           = 4;
    localparam int THRESHOLD_COUNT = 4;
    localparam int KEY_BITS        = 64;

    localparam int ENTRIES  = TURNS * CAPACITY;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int TURN_W   = (TURNS > 1) ? $clog2(TURNS) : 1;
    localparam int ADDR_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int OCC_W    = $clog2(CAPACITY + 1);
    localparam int COUNT_W  = 32;
    localparam int STAMP_W  = 48;
    localparam int WORD_W   = 1 + KEY_BITS + COUNT_W + STAMP_W;
    localparam int THR_USED = (THRESHOLD_COUNT < 4) ? THRESHOLD_COUNT : 4;
    localparam int DEFAULT_LIMIT = 256;

    typedef enum logic [1:0] {
        CMD_NOTE    = 2'd0,
        CMD_QUERY   = 2'd1,
        CMD_END     = 2'd2,
        CMD_CLR_ALL = 2'd3
    } cmd_t;

    localparam logic [2:0] REG_KEY_LIMIT = 3'd0;
    localparam logic [2:0] REG_THR_A     = 3'd1;
    localparam logic [2:0] REG_THR_B     = 3'd2;
    localparam logic [2:0] REG_THR_C     = 3'd3;
    localparam logic [2:0] REG_THR_D     = 3'd4;

    typedef struct packed {
        logic [8:0]       key_limit;
        logic [3:0][31:0] thr;
    } cfg_t;

    typedef struct packed {
        logic load;
        logic clr_start;
        logic scan_start;
        logic query_res;
        logic upd;
        logic evict;
        logic out_load;
    } dp_cmd_t;

    typedef struct packed {
        cmd_t cmd;
        logic key_ok;
        logic turn_ok;
        logic clr_busy;
        logic scan_done;
        logic over_limit;
        logic out_free;
    } dp_stat_t;

endpackage
`default_nettype wire

// ===== hdl/rclc_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
module rclc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                   aclk,
    input  wire logic                                   we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                       wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                       rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

// ===== hdl/rclc_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
module rclc_ctrl import rclc_pkg::*; (
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     s_tvalid,
    output logic          s_tready,
    input  wire dp_stat_t st,
    output dp_cmd_t       ctl
);
    typedef enum logic [8:0] {
        ST_INIT   = 9'b000000001,
        ST_IDLE   = 9'b000000010,
        ST_DEC    = 9'b000000100,
        ST_CLR    = 9'b000001000,
        ST_SCAN   = 9'b000010000,
        ST_UPD    = 9'b000100000,
        ST_EVCHK  = 9'b001000000,
        ST_EVSCAN = 9'b010000000,
        ST_DONE   = 9'b100000000
    } state_t;

    state_t state_reg, state_next;

    assign s_tready = (state_reg == ST_IDLE);

    always_comb begin
        state_next = state_reg;
        ctl        = '0;
        ctl.load   = s_tvalid && s_tready;
        case (state_reg)
            ST_INIT: begin
                if (!st.clr_busy) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_DEC;
                end
            end
            ST_DEC: begin
                if (st.cmd == CMD_CLR_ALL || (st.cmd == CMD_END && st.turn_ok)) begin
                    ctl.clr_start = 1'b1;
                    state_next    = ST_CLR;
                end else if (st.cmd != CMD_END && st.key_ok) begin
                    ctl.scan_start = 1'b1;
                    state_next     = ST_SCAN;
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_CLR: begin
                if (!st.clr_busy) begin
                    state_next = ST_DONE;
                end
            end
            ST_SCAN: begin
                if (st.scan_done) begin
                    if (st.cmd == CMD_QUERY) begin
                        ctl.query_res = 1'b1;
                        state_next    = ST_DONE;
                    end else begin
                        state_next = ST_UPD;
                    end
                end
            end
            ST_UPD: begin
                ctl.upd    = 1'b1;
                state_next = ST_EVCHK;
            end
            ST_EVCHK: begin
                if (st.over_limit) begin
                    ctl.scan_start = 1'b1;
                    state_next     = ST_EVSCAN;
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_EVSCAN: begin
                // drop the oldest once the pass is over, then check again
                if (st.scan_done) begin
                    ctl.evict  = 1'b1;
                    state_next = ST_EVCHK;
                end
            end
            ST_DONE: begin
                if (st.out_free) begin
                    ctl.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_INIT;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_INIT;
        end else begin
            state_reg <= state_next;
        end
    end
endmodule
`default_nettype wire

// ===== hdl/rclc_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none
module rclc_dp import rclc_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic [1:0]  in_cmd,
    input  wire logic [1:0]  in_turn,
    input  wire logic        in_present,
    input  wire logic [63:0] in_key,
    input  wire cfg_t        cfg,
    input  wire dp_cmd_t     ctl,
    output dp_stat_t         st,
    output logic             m_tvalid,
    output logic [39:0]      m_tdata,
    input  wire logic        m_tready
);
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
    localparam logic [STAMP_W-1:0] CLOCK_MAX = '1;

    cmd_t                               cmd_reg;
    logic [1:0]                         turn_reg;
    logic                               present_reg;
    logic [KEY_BITS-1:0]                key_reg;
    logic [TURNS-1:0][OCC_W-1:0]        occ_reg;
    logic [TURNS-1:0][STAMP_W-1:0]      tclk_reg;
    logic                               issue_reg, pend_reg, scan_done_reg;
    logic [IDX_W-1:0]                   idx_reg, pidx_reg;
    logic                               found_reg, free_found_reg, old_found_reg;
    logic [IDX_W-1:0]                   found_idx_reg, free_idx_reg, old_idx_reg;
    logic [COUNT_W-1:0]                 found_cnt_reg;
    logic [STAMP_W-1:0]                 old_stamp_reg;
    logic                               clr_busy_reg, clr_all_reg;
    logic [ADDR_W-1:0]                  clr_idx_reg;
    logic [COUNT_W-1:0]                 res_cnt_reg, out_cnt_reg;
    logic                               res_hit_reg, out_hit_reg, mval_reg;

    logic [TURN_W-1:0]   tidx;
    logic [OCC_W-1:0]    occ_cur;
    logic [STAMP_W-1:0]  tclk_cur, new_clk;
    logic [COUNT_W-1:0]  new_cnt;
    logic [IDX_W-1:0]    upd_idx;
    logic                tbl_full;
    logic [31:0]         limit;
    logic                we;
    logic [ADDR_W-1:0]   waddr, raddr;
    logic [WORD_W-1:0]   wdata, rdata;
    logic                rd_valid;
    logic [KEY_BITS-1:0] rd_key;
    logic [COUNT_W-1:0]  rd_cnt;
    logic [STAMP_W-1:0]  rd_stamp;
    logic                clr_last;

    function automatic logic [ADDR_W-1:0] ent_addr(input logic [1:0] t,
                                                   input logic [IDX_W-1:0] i);
        return ADDR_W'(32'(t) * CAPACITY + 32'(i));
    endfunction

    function automatic logic thr_match(input cfg_t c, input logic [COUNT_W-1:0] n);
        logic m;
        m = 1'b0;
        for (int i = 0; i < THR_USED; i++) begin
            if (c.thr[i] != '0 && c.thr[i] == n) begin
                m = 1'b1;
            end
        end
        return m;
    endfunction

    assign tidx     = TURN_W'(turn_reg);
    assign occ_cur  = occ_reg[tidx];
    assign tclk_cur = tclk_reg[tidx];
    assign new_clk  = (tclk_cur == CLOCK_MAX) ? tclk_cur : tclk_cur + STAMP_W'(1);
    assign tbl_full = 32'(occ_cur) >= CAPACITY;
    assign new_cnt  = !found_reg ? COUNT_W'(1) :
                      (found_cnt_reg == COUNT_MAX) ? COUNT_MAX :
                      found_cnt_reg + COUNT_W'(1);
    // a miss on a full table reuses the oldest slot
    assign upd_idx  = found_reg ? found_idx_reg : (tbl_full ? old_idx_reg : free_idx_reg);

    always_comb begin
        if (cfg.key_limit == '0) begin
            limit = 32'(DEFAULT_LIMIT);
        end else begin
            limit = 32'(cfg.key_limit);
        end
        if (limit > 32'(CAPACITY)) begin
            limit = 32'(CAPACITY);
        end
    end

    assign clr_last = clr_all_reg ? (32'(clr_idx_reg) == ENTRIES - 1)
                                  : (32'(clr_idx_reg) == CAPACITY - 1);

    always_comb begin
        we    = 1'b0;
        waddr = ent_addr(turn_reg, upd_idx);
        wdata = '0;
        if (clr_busy_reg) begin
            we    = 1'b1;
            waddr = clr_all_reg ? clr_idx_reg
                                : ent_addr(turn_reg, IDX_W'(clr_idx_reg));
        end else if (ctl.upd) begin
            we    = 1'b1;
            wdata = {1'b1, key_reg, new_cnt, new_clk};
        end else if (ctl.evict) begin
            we    = 1'b1;
            waddr = ent_addr(turn_reg, old_idx_reg);
        end
    end

    assign raddr = ent_addr(turn_reg, idx_reg);

    rclc_ram #(
        .WIDTH(WORD_W),
        .DEPTH(ENTRIES)
    ) u_ram (
        .aclk (aclk),
        .we   (we),
        .waddr(waddr),
        .wdata(wdata),
        .raddr(raddr),
        .rdata(rdata)
    );

    assign rd_valid = rdata[WORD_W-1];
    assign rd_key   = rdata[STAMP_W+COUNT_W +: KEY_BITS];
    assign rd_cnt   = rdata[STAMP_W +: COUNT_W];
    assign rd_stamp = rdata[STAMP_W-1:0];

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            occ_reg       <= '0;
            tclk_reg      <= '0;
            issue_reg     <= 1'b0;
            pend_reg      <= 1'b0;
            scan_done_reg <= 1'b0;
            clr_busy_reg  <= 1'b1;
            clr_all_reg   <= 1'b1;
            clr_idx_reg   <= '0;
            mval_reg      <= 1'b0;
        end else begin
            // flag the pass once the last entry's compare has landed
            scan_done_reg <= !ctl.scan_start && pend_reg &&
                             (32'(pidx_reg) == CAPACITY - 1);
            if (ctl.scan_start) begin
                issue_reg <= 1'b1;
                pend_reg  <= 1'b0;
            end else begin
                pend_reg <= issue_reg;
                if (issue_reg && 32'(idx_reg) == CAPACITY - 1) begin
                    issue_reg <= 1'b0;
                end
            end

            if (ctl.clr_start) begin
                clr_busy_reg <= 1'b1;
                clr_all_reg  <= (cmd_reg == CMD_CLR_ALL);
                clr_idx_reg  <= '0;
                for (int i = 0; i < TURNS; i++) begin
                    if (cmd_reg == CMD_CLR_ALL || 32'(turn_reg) == i) begin
                        occ_reg[i]  <= '0;
                        tclk_reg[i] <= '0;
                    end
                end
            end else if (clr_busy_reg) begin
                clr_idx_reg <= clr_idx_reg + ADDR_W'(1);
                if (clr_last) begin
                    clr_busy_reg <= 1'b0;
                end
            end

            if (ctl.upd) begin
                tclk_reg[tidx] <= new_clk;
                if (!found_reg && !tbl_full) begin
                    occ_reg[tidx] <= occ_cur + OCC_W'(1);
                end
            end else if (ctl.evict && occ_cur != '0) begin
                occ_reg[tidx] <= occ_cur - OCC_W'(1);
            end

            if (ctl.out_load) begin
                mval_reg <= 1'b1;
            end else if (m_tready) begin
                mval_reg <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (ctl.load) begin
            cmd_reg     <= cmd_t'(in_cmd);
            turn_reg    <= in_turn;
            present_reg <= in_present;
            key_reg     <= in_key[KEY_BITS-1:0];
            res_cnt_reg <= '0;
            res_hit_reg <= 1'b0;
        end

        if (ctl.scan_start) begin
            idx_reg        <= '0;
            found_reg      <= 1'b0;
            free_found_reg <= 1'b0;
            old_found_reg  <= 1'b0;
        end else begin
            if (issue_reg) begin
                idx_reg  <= idx_reg + IDX_W'(1);
                pidx_reg <= idx_reg;
            end
            if (pend_reg) begin
                if (rd_valid && rd_key == key_reg && !found_reg) begin
                    found_reg     <= 1'b1;
                    found_idx_reg <= pidx_reg;
                    found_cnt_reg <= rd_cnt;
                end
                if (!rd_valid && !free_found_reg) begin
                    free_found_reg <= 1'b1;
                    free_idx_reg   <= pidx_reg;
                end
                // strict compare keeps the lowest index on a tie
                if (rd_valid && (!old_found_reg || rd_stamp < old_stamp_reg)) begin
                    old_found_reg <= 1'b1;
                    old_idx_reg   <= pidx_reg;
                    old_stamp_reg <= rd_stamp;
                end
            end
        end

        if (ctl.upd) begin
            res_cnt_reg <= new_cnt;
            res_hit_reg <= thr_match(cfg, new_cnt);
        end else if (ctl.query_res) begin
            res_cnt_reg <= found_reg ? found_cnt_reg : '0;
            res_hit_reg <= 1'b0;
        end

        if (ctl.out_load) begin
            out_cnt_reg <= res_cnt_reg;
            out_hit_reg <= res_hit_reg;
        end
    end

    assign st.cmd        = cmd_reg;
    assign st.turn_ok    = 32'(turn_reg) < TURNS;
    assign st.key_ok     = present_reg && (32'(turn_reg) < TURNS);
    assign st.clr_busy   = clr_busy_reg;
    assign st.scan_done  = scan_done_reg;
    assign st.over_limit = 32'(occ_cur) > limit;
    assign st.out_free   = !mval_reg || m_tready;

    assign m_tvalid = mval_reg;
    assign m_tdata  = {7'b0, out_hit_reg, out_cnt_reg};
endmodule
`default_nettype wire

// ===== hdl/repeat_call_lru_counter.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Channel    | Direction | Handshake         | Content
// s_ (in)    | slave     | s_tvalid/s_tready | tuser cmd, tdata slot/present/key
// m_ (out)   | master    | m_tvalid/m_tready | tdata seen_count, threshold_hit
// APB (cfg)  | slave     | psel/penable      | key_limit, threshold_a..d
//
// One request at a time. A note makes a lookup pass through the entry RAM read port, plus
// one more pass for each entry evicted; a query makes a single pass. Ending a turn sweeps
// that turn's CAPACITY entries, clearing all sweeps all TURNS*CAPACITY. After reset the
// entry RAM is swept and s_tready stays low until the sweep is done.
// A finished result waits in the output register while the next request is taken.
module repeat_call_lru_counter import rclc_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [71:0] s_tdata,   // turn_slot[1:0], key_present[2], call_key[66:3]
    input  wire logic [1:0]  s_tuser,   // cmd[1:0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [39:0]      m_tdata,   // seen_count[31:0], threshold_hit[32]
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    cfg_t       cfg_reg;
    dp_cmd_t    ctl;
    dp_stat_t   st;
    logic [2:0] reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.key_limit <= 9'd256;
            cfg_reg.thr[0]    <= 32'd5;
            cfg_reg.thr[1]    <= 32'd10;
            cfg_reg.thr[2]    <= 32'd20;
            cfg_reg.thr[3]    <= 32'd0;
        end else if (psel && penable && pwrite && pready) begin
            case (reg_idx)
                REG_KEY_LIMIT: cfg_reg.key_limit <= pwdata[8:0];
                REG_THR_A:     cfg_reg.thr[0]    <= pwdata;
                REG_THR_B:     cfg_reg.thr[1]    <= pwdata;
                REG_THR_C:     cfg_reg.thr[2]    <= pwdata;
                REG_THR_D:     cfg_reg.thr[3]    <= pwdata;
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_KEY_LIMIT: prdata = {23'b0, cfg_reg.key_limit};
            REG_THR_A:     prdata = cfg_reg.thr[0];
            REG_THR_B:     prdata = cfg_reg.thr[1];
            REG_THR_C:     prdata = cfg_reg.thr[2];
            REG_THR_D:     prdata = cfg_reg.thr[3];
            default:       prdata = '0;
        endcase
    end

    rclc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .st      (st),
        .ctl     (ctl)
    );

    rclc_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_cmd    (s_tuser),
        .in_turn   (s_tdata[1:0]),
        .in_present(s_tdata[2]),
        .in_key    (s_tdata[66:3]),
        .cfg       (cfg_reg),
        .ctl       (ctl),
        .st        (st),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata),
        .m_tready  (m_tready)
    );
endmodule
`default_nettype wire

// ===== hdl/rclc_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
module rclc_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [39:0] m_tdata
);
    // hold a stalled result
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // reset starts the clearing sweep: no request taken, no result shown
    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !s_tready && !m_tvalid)
        else $error("activity right after reset");

    a_hit_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[32] |-> m_tdata[31:0] != 32'd0)
        else $error("threshold hit on zero count");

    a_pad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[39:33] == 7'd0)
        else $error("result padding not zero");
endmodule

bind repeat_call_lru_counter rclc_checker u_rclc_checker (.*);
`default_nettype wire

// ===== verif/repeat_call_lru_counter_test.sv =====
`timescale 1ns / 1ps
module repeat_call_lru_counter_test;
    import rclc_pkg::*;

    localparam logic [2:0] REG_SPARE = 3'd5;  // unmapped address, write must be dropped
    localparam int TAIL_CYCLES = 600;

    typedef struct packed {
        logic [31:0] count;
        logic        hit;
    } tally_t;

    typedef struct {
        cmd_t        cmd;
        logic [1:0]  slot;
        logic        present;
        logic [63:0] key;
        bit          typed;
        logic [31:0] count;
        logic        hit;
    } plan_row_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    wire         s_tready;
    logic [71:0] s_tdata = '0;   // turn_slot[1:0], key_present[2], call_key[66:3]
    logic [1:0]  s_tuser = '0;   // cmd[1:0]
    wire         m_tvalid;
    logic        m_tready = 1'b0;
    wire  [39:0] m_tdata;        // seen_count[31:0], threshold_hit[32]
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    wire  [31:0] prdata;
    wire         pready;

    repeat_call_lru_counter i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always #6 aclk = ~aclk;

    // shadow of the turn tables
    bit          tab_valid [TURNS][CAPACITY];
    logic [63:0] tab_key   [TURNS][CAPACITY];
    logic [31:0] tab_count [TURNS][CAPACITY];
    logic [47:0] tab_stamp [TURNS][CAPACITY];
    int          tab_occ   [TURNS];
    logic [47:0] turn_clk  [TURNS];
    logic [8:0]  lim_reg = 9'd256;
    logic [31:0] thr_reg [4] = '{32'd5, 32'd10, 32'd20, 32'd0};

    tally_t expected_tallies [$];
    int     failures = 0;
    int     results_seen = 0;
    int     stall_left = 0;
    bit     steady = 1'b0;
    logic [63:0] key_pool [64];
    logic [63:0] last_key = '0;

    function automatic void wipe_turn(int t);
        for (int i = 0; i < CAPACITY; i++) tab_valid[t][i] = 1'b0;
        tab_occ[t] = 0;
        turn_clk[t] = '0;
    endfunction

    function automatic void evict_least_recent(int t);
        int best;
        best = -1;
        for (int i = 0; i < CAPACITY; i++)
            if (tab_valid[t][i] && (best < 0 || tab_stamp[t][i] < tab_stamp[t][best]))
                best = i;
        if (best >= 0) begin
            tab_valid[t][best] = 1'b0;
            if (tab_occ[t] > 0) tab_occ[t]--;
        end
    endfunction

    function automatic tally_t tally_request(cmd_t cmd, logic [1:0] slot, logic present,
                                             logic [63:0] key);
        tally_t r;
        int     e;
        int     lim;
        r = '0;
        e = -1;
        if (cmd == CMD_CLR_ALL) begin
            for (int t = 0; t < TURNS; t++) wipe_turn(t);
        end else if (cmd == CMD_END) begin
            wipe_turn(slot);
        end else if (present) begin
            for (int i = 0; i < CAPACITY; i++)
                if (e < 0 && tab_valid[slot][i] && tab_key[slot][i] == key) e = i;
            if (cmd == CMD_QUERY) begin
                if (e >= 0) r.count = tab_count[slot][e];
            end else begin
                lim = (lim_reg == 0) ? DEFAULT_LIMIT : int'(lim_reg);
                if (lim > CAPACITY) lim = CAPACITY;
                if (turn_clk[slot] != '1) turn_clk[slot]++;
                if (e >= 0) begin
                    if (tab_count[slot][e] != '1) tab_count[slot][e]++;
                end else begin
                    if (tab_occ[slot] >= CAPACITY) evict_least_recent(slot);
                    for (int i = 0; i < CAPACITY; i++)
                        if (e < 0 && !tab_valid[slot][i]) e = i;
                    tab_valid[slot][e] = 1'b1;
                    tab_key[slot][e] = key;
                    tab_count[slot][e] = 32'd1;
                    tab_occ[slot]++;
                end
                tab_stamp[slot][e] = turn_clk[slot];
                r.count = tab_count[slot][e];
                while (tab_occ[slot] > lim) evict_least_recent(slot);
                for (int i = 0; i < THR_USED; i++)
                    if (thr_reg[i] != 0 && thr_reg[i] == r.count) r.hit = 1'b1;
            end
        end
        return r;
    endfunction

    task automatic push_request(cmd_t cmd, logic [1:0] slot, logic present, logic [63:0] key,
                                bit typed = 1'b0, tally_t typed_val = '0);
        tally_t predicted;
        while (!steady && $urandom_range(99) < 16) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {5'd0, key, present, slot};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predicted = tally_request(cmd, slot, present, key);
        expected_tallies.push_back(typed ? typed_val : predicted);
    endtask

    task automatic drain;
        s_tvalid <= 1'b0;
        while (expected_tallies.size() != 0) @(posedge aclk);
    endtask

    task automatic apb_write(logic [2:0] idx, logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        if (idx == REG_KEY_LIMIT) lim_reg = val[8:0];
        else if (idx >= REG_THR_A && idx <= REG_THR_D) thr_reg[idx - REG_THR_A] = val;
    endtask

    task automatic load_settings(logic [31:0] lim, logic [31:0] a, logic [31:0] b,
                                 logic [31:0] c, logic [31:0] d);
        apb_write(REG_KEY_LIMIT, lim);
        apb_write(REG_THR_A, a);
        apb_write(REG_THR_B, b);
        apb_write(REG_THR_C, c);
        apb_write(REG_THR_D, d);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    // fill: fresh keys into turn 1 only, so the table overflows its capacity
    task automatic run_phase(int n, int pool_n, bit fill);
        int          r;
        cmd_t        cmd;
        logic [63:0] key;
        logic [1:0]  slot;
        for (int i = 0; i < pool_n; i++) key_pool[i] = {$urandom, $urandom};
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(99);
            if (fill) begin
                slot = 2'd1;
                if (r < 92) begin
                    cmd = CMD_NOTE;
                    key = {$urandom, $urandom};
                    last_key = key;
                end else begin
                    cmd = CMD_QUERY;
                    key = (r < 96) ? last_key : {$urandom, $urandom};
                end
            end else begin
                slot = 2'($urandom_range(3));
                cmd = (r < 68) ? CMD_NOTE : (r < 90) ? CMD_QUERY : (r < 98) ? CMD_END
                    : CMD_CLR_ALL;
                key = ($urandom_range(9) == 0) ? {$urandom, $urandom}
                    : key_pool[$urandom_range(pool_n - 1)];
            end
            push_request(cmd, slot, $urandom_range(19) != 0, key);
        end
    endtask

    // result side: random back-pressure plus one long hold-off
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                results_seen <= results_seen + 1;
                if (expected_tallies.size() == 0) begin
                    $error("unexpected result: seen_count %0d threshold_hit %0b",
                           m_tdata[31:0], m_tdata[32]);
                    failures++;
                end else begin
                    tally_t want;
                    want = expected_tallies.pop_front();
                    if (m_tdata[31:0] !== want.count) begin
                        $error("seen_count: expected %0d, actual %0d", want.count,
                               m_tdata[31:0]);
                        failures++;
                    end
                    if (m_tdata[32] !== want.hit) begin
                        $error("threshold_hit: expected %0b, actual %0b", want.hit,
                               m_tdata[32]);
                        failures++;
                    end
                end
            end
            if (stall_left != 0) begin
                stall_left <= stall_left - 1;
                m_tready <= 1'b0;
            end else if (m_tvalid && m_tready && results_seen == 150) begin
                stall_left <= 4000;
                m_tready <= 1'b0;
            end else begin
                m_tready <= steady || ($urandom_range(99) >= 16);
            end
        end
    end

    initial begin
        #40_000_000;
        $display("Test completed with failures");
        $finish;
    end

    initial begin
        plan_row_t plan [20];
        logic [63:0] k_a;
        k_a = 64'h0123_4567_89AB_CDEF;
        plan = '{
            '{CMD_QUERY,   2'd0, 1'b1, k_a,     1'b1, 32'd0, 1'b0},
            '{CMD_NOTE,    2'd0, 1'b1, k_a,     1'b1, 32'd1, 1'b0},
            '{CMD_NOTE,    2'd3, 1'b1, '1,      1'b1, 32'd1, 1'b0},
            '{CMD_NOTE,    2'd0, 1'b1, '0,      1'b1, 32'd1, 1'b0},
            '{CMD_NOTE,    2'd0, 1'b1, k_a,     1'b1, 32'd2, 1'b0},
            '{CMD_NOTE,    2'd0, 1'b1, k_a,     1'b1, 32'd3, 1'b0},
            '{CMD_NOTE,    2'd0, 1'b1, k_a,     1'b1, 32'd4, 1'b0},
            '{CMD_NOTE,    2'd0, 1'b1, k_a,     1'b1, 32'd5, 1'b1},
            '{CMD_NOTE,    2'd0, 1'b0, k_a,     1'b1, 32'd0, 1'b0},
            '{CMD_QUERY,   2'd0, 1'b0, k_a,     1'b1, 32'd0, 1'b0},
            '{CMD_QUERY,   2'd0, 1'b1, k_a,     1'b1, 32'd5, 1'b0},
            '{CMD_NOTE,    2'd2, 1'b1, k_a,     1'b0, 32'd0, 1'b0},
            '{CMD_QUERY,   2'd2, 1'b1, '0,      1'b1, 32'd0, 1'b0},
            '{CMD_END,     2'd0, 1'b1, k_a,     1'b1, 32'd0, 1'b0},
            '{CMD_QUERY,   2'd0, 1'b1, k_a,     1'b1, 32'd0, 1'b0},
            '{CMD_QUERY,   2'd3, 1'b1, '1,      1'b1, 32'd1, 1'b0},
            '{CMD_NOTE,    2'd1, 1'b1, '1,      1'b0, 32'd0, 1'b0},
            '{CMD_CLR_ALL, 2'd2, 1'b1, k_a,     1'b1, 32'd0, 1'b0},
            '{CMD_QUERY,   2'd3, 1'b1, '1,      1'b1, 32'd0, 1'b0},
            '{CMD_QUERY,   2'd1, 1'b1, '1,      1'b1, 32'd0, 1'b0}
        };
        for (int t = 0; t < TURNS; t++) wipe_turn(t);
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (plan[i])
            push_request(plan[i].cmd, plan[i].slot, plan[i].present, plan[i].key,
                         plan[i].typed, '{count: plan[i].count, hit: plan[i].hit});
        drain();

        // zero limit acts as full capacity; overflow turn 1 past 256 keys
        load_settings(32'd0, 32'd1, 32'd2, 32'd3, 32'd4);
        run_phase(300, 0, 1'b1);
        drain();

        // drop the limit under a full table, thresholds at the extremes
        load_settings(32'd2, 32'hFFFF_FFFF, 32'd0, 32'd1, 32'd3);
        run_phase(250, 6, 1'b0);
        drain();

        apb_write(REG_SPARE, 32'd1);
        load_settings(32'd511, 32'd0, 32'd2, 32'd3, 32'd0);
        run_phase(300, 40, 1'b0);
        drain();

        load_settings(32'd7, 32'd5, 32'd10, 32'd20, 32'd0);
        steady = 1'b1;
        run_phase(150, 12, 1'b0);
        steady = 1'b0;
        run_phase(150, 12, 1'b0);
        drain();

        repeat (TAIL_CYCLES) @(posedge aclk);
        if (failures == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
